// File: hdl/sfla_pkg.sv
// Shared types and constants for the slot free-list allocator.
package sfla_pkg;

  // Fixed field widths of the stream payload.
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // Request kinds.
  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } sfla_kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_INVALID      = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } sfla_status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } sfla_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and start the table reads
    logic commit;   // update the tables and load the result register
  } sfla_cmd_t;

endpackage

// File: hdl/sfla_ctrl.sv
// Controller state machine for the slot free-list allocator.
module sfla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output sfla_pkg::sfla_cmd_t cmd_o
);
  import sfla_pkg::*;

  sfla_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      S_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Result valid flag: set by a commit, cleared when the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/sfla_datapath.sv
// Datapath of the slot free-list allocator: link and in-use tables, head and counters.
module sfla_datapath #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfla_pkg::sfla_cmd_t                cmd_i,
  input  logic                               req_kind_i,
  input  logic [sfla_pkg::SLOT_W-1:0]        req_slot_i,
  output logic [sfla_pkg::SLOT_W-1:0]        granted_slot_o,
  output logic [sfla_pkg::STATUS_W-1:0]      status_o,
  output logic [sfla_pkg::COUNT_W-1:0]       used_count_o
);
  import sfla_pkg::*;

  localparam int unsigned IW = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned HW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CW = ((HW > SLOT_W) ? HW : SLOT_W) + 1;
  localparam int unsigned XW = IW + SLOT_W;
  localparam logic [CW-1:0] NUM_SLOTS_C = CW'(NUM_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT   = IW'(NUM_SLOTS - 1);

  // Tables; entries at or above the fresh mark have never been written.
  logic [IW-1:0] link_mem [NUM_SLOTS];
  logic          flag_mem [NUM_SLOTS];

  logic [IW-1:0]      head_q, head_d;
  logic [HW-1:0]      fresh_q, fresh_d;
  logic [COUNT_W-1:0] used_q, used_d;

  // Request latched at acceptance and registered table reads.
  sfla_kind_e         kind_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [IW-1:0]      link_rd_q;
  logic               flag_rd_q;

  logic [SLOT_W-1:0]  granted_q, granted_d;
  sfla_status_e       status_q, status_d;

  logic [XW-1:0]      req_slot_x;
  logic [IW-1:0]      req_idx;
  logic [XW-1:0]      slot_x;
  logic [IW-1:0]      slot_idx;
  logic [CW-1:0]      slot_c;
  logic [CW-1:0]      head_c;
  logic [CW-1:0]      fresh_c;
  logic               head_fresh;
  logic [IW-1:0]      fresh_link;
  logic [IW-1:0]      head_link;
  logic               slot_in_use;
  logic               link_we;
  logic               flag_we;
  logic [IW-1:0]      flag_addr;
  logic               flag_wdata;

  // Slot numbers resized to the table index width.
  assign req_slot_x = XW'(req_slot_i);
  assign req_idx    = req_slot_x[IW-1:0];
  assign slot_x     = XW'(slot_q);
  assign slot_idx   = slot_x[IW-1:0];
  assign slot_c     = CW'(slot_q);
  assign head_c     = CW'(head_q);
  assign fresh_c    = CW'(fresh_q);

  // Untouched entries are read as their initial link and a clear in-use flag.
  assign head_fresh  = (head_c == fresh_c);
  assign fresh_link  = (head_q == LAST_SLOT) ? '0 : head_q + IW'(1);
  assign head_link   = head_fresh ? fresh_link : link_rd_q;
  assign slot_in_use = (slot_c < fresh_c) && flag_rd_q;

  // Request evaluation and state update.
  always_comb begin
    head_d     = head_q;
    fresh_d    = fresh_q;
    used_d     = used_q;
    granted_d  = '0;
    status_d   = ST_OK;
    link_we    = 1'b0;
    flag_we    = 1'b0;
    flag_addr  = slot_idx;
    flag_wdata = 1'b0;
    if (kind_q == KIND_ALLOC) begin
      if (head_q == '0) begin
        status_d = ST_FULL;
      end else begin
        granted_d  = SLOT_W'(head_q);
        head_d     = head_link;
        used_d     = used_q + COUNT_W'(1);
        flag_we    = 1'b1;
        flag_addr  = head_q;
        flag_wdata = 1'b1;
        if (head_fresh) begin
          fresh_d = fresh_q + HW'(1);
        end
      end
    end else begin
      if ((slot_q == '0) || (slot_c >= NUM_SLOTS_C)) begin
        status_d = ST_INVALID;
      end else if (!slot_in_use) begin
        status_d = ST_ALREADY_FREE;
      end else begin
        link_we = 1'b1;
        flag_we = 1'b1;
        head_d  = slot_idx;
        used_d  = used_q - COUNT_W'(1);
      end
    end
  end

  // Control registers of the free list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= IW'(1);
      fresh_q <= HW'(1);
      used_q  <= '0;
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      fresh_q <= fresh_d;
      used_q  <= used_d;
    end
  end

  // Request capture and table reads at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= sfla_kind_e'(req_kind_i);
      slot_q    <= req_slot_i;
      link_rd_q <= link_mem[head_q];
      flag_rd_q <= flag_mem[req_idx];
    end
  end

  // Table writes at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && link_we) begin
      link_mem[slot_idx] <= head_q;
    end
    if (cmd_i.commit && flag_we) begin
      flag_mem[flag_addr] <= flag_wdata;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      status_q  <= status_d;
    end
  end

  assign granted_slot_o = granted_q;
  assign status_o       = status_q;
  assign used_count_o   = used_q;

endmodule

// File: hdl/slot_free_list_allocator_unit.sv
// Top level of the slot free-list allocator.
//
// A pool of NUM_SLOTS slot numbers kept as a last-in first-out free list; slot 0 is
// reserved. Each request on the slave stream (tuser: 0 allocate, 1 release) gives one
// result on the master stream: the granted slot, a status (0 ok, 1 pool full, 2 invalid
// slot, 3 slot already free) and the count of slots in use afterwards. A request first
// reads the link and in-use tables synchronously, then updates them and loads the result
// register. The next request is taken while a result waits to be read; the block stalls
// only when that result register is still full at update time. No clearing pass is needed
// after reset: slots never handed out are tracked by a fill mark and read back as if they
// held their reset contents.
module slot_free_list_allocator_unit #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] slot, [7:6] zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] granted_slot, [11:6] used_count, [15:12] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import sfla_pkg::*;

  sfla_cmd_t            cmd;
  logic [SLOT_W-1:0]    granted_slot;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   used_count;

  // Handshake and sequencing.
  sfla_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // Free-list tables and result formation.
  sfla_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_kind_i     (s_axis_tuser),
    .req_slot_i     (s_axis_tdata[SLOT_W-1:0]),
    .granted_slot_o (granted_slot),
    .status_o       (status),
    .used_count_o   (used_count)
  );

  // Result packing.
  assign m_axis_tdata = {(OUT_TDATA_W - SLOT_W - COUNT_W)'(0), used_count, granted_slot};
  assign m_axis_tuser = status;

endmodule
